/* rtl/iptm_pkg.sv */
// ----------------------------------------------------------------------------
// iptm_pkg
// Shared types and constants for the ip to mac learning table.
// ----------------------------------------------------------------------------
package iptm_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC
    } state_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED   = 3'd0,
        STAT_SKIPPED = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_HIT     = 3'd3,
        STAT_MISS    = 3'd4
    } status_t;

    typedef enum logic {
        FUNC_LEARN  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_FIXED = 1'b0,
        CFG_FIXED_MAC = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef struct packed {
        logic            shift;
        logic            cmp;
        logic            active;
        logic [IP_W-1:0] key;
    } cell_ctrl_t;

    typedef struct packed {
        logic             match;
        logic [MAC_W-1:0] mac;
    } cell_stat_t;

endpackage

/* rtl/ip_to_mac_learning_table_unit.sv */
// ----------------------------------------------------------------------------
// ip_to_mac_learning_table_unit
// Learns ip/mac pairs from received headers and answers mac lookups.
// ----------------------------------------------------------------------------
// s_axis carries one request word: tuser is the function (learn or lookup),
// tdata holds ip then mac. m_axis returns one word per request: tuser is the
// status code, tdata the mac (zero but for a lookup hit or a fixed-mode lookup).
// cfg writes use_fixed_mac (index 0) or fixed_mac (index 1); always ready.
// The table is a row of slot cells. A new pair enters the first cell and every
// filled cell hands its pair to the next one, so slots below the fill count
// are the live entries. A request is compared in all cells at once in the
// compare step, and the registered per-cell results are merged and the table
// updated in the decide step. Each request passes accept, compare, then
// decide; a new request is taken only once the last has left decide.
// s_axis_tready stays low while a request is in flight. A stalled m_axis holds
// its word; the next request is still taken but waits in the decide step, and
// no further one is accepted until the held word is taken.
// Reset empties the table (fill count zero) and clears the configuration.
// ----------------------------------------------------------------------------
module ip_to_mac_learning_table_unit #(
    parameter int TABLE_ENTRIES = iptm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [iptm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // ip_addr, src_mac
    input  logic                             s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [iptm_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // mac_out
    output logic [iptm_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iptm_pkg::MAC_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    iptm_pkg::state_t state_reg, state_next;

    logic                        use_fixed_reg;
    logic [iptm_pkg::MAC_W-1:0]  fixed_mac_reg;

    logic                        func_reg;
    logic [iptm_pkg::IP_W-1:0]   key_reg;
    logic [iptm_pkg::MAC_W-1:0]  mac_in_reg;

    logic [CNT_W-1:0]            count_reg, count_next;

    logic                        m_valid_reg, m_valid_next;
    iptm_pkg::status_t           m_status_reg;
    logic [iptm_pkg::MAC_W-1:0]  m_mac_reg;

    logic                        s_accept;
    logic                        cmp_en;
    logic                        out_load;
    logic                        shift_en;
    iptm_pkg::status_t           status_next;
    logic [iptm_pkg::MAC_W-1:0]  mac_next;

    iptm_pkg::cell_ctrl_t        cell_ctrl [TABLE_ENTRIES];
    iptm_pkg::cell_stat_t        cell_stat [TABLE_ENTRIES];
    iptm_pkg::entry_t            chain     [TABLE_ENTRIES];
    iptm_pkg::entry_t            new_entry;
    logic [TABLE_ENTRIES-1:0]    match_vec;
    logic                        any_hit;
    logic [iptm_pkg::MAC_W-1:0]  hit_mac;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_fixed_reg <= 1'b0;
            fixed_mac_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (iptm_pkg::cfg_idx_t'(cfg_index))
                iptm_pkg::CFG_USE_FIXED: use_fixed_reg <= cfg_data[0];
                iptm_pkg::CFG_FIXED_MAC: fixed_mac_reg <= cfg_data;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg   <= s_axis_tuser;
            key_reg    <= s_axis_tdata[iptm_pkg::IP_W-1:0];
            mac_in_reg <= s_axis_tdata[iptm_pkg::IP_W +: iptm_pkg::MAC_W];
        end
    end

    // slot cells
    assign new_entry.ip  = key_reg;
    assign new_entry.mac = mac_in_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        assign cell_ctrl[i].shift  = shift_en;
        assign cell_ctrl[i].cmp    = cmp_en;
        assign cell_ctrl[i].active = (count_reg > CNT_W'(i));
        assign cell_ctrl[i].key    = key_reg;
        assign match_vec[i]        = cell_stat[i].match;

        if (i == 0) begin : g_head
            iptm_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[i]),
                .entry_in  (new_entry),
                .entry_out (chain[i]),
                .stat      (cell_stat[i])
            );
        end else begin : g_body
            iptm_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[i]),
                .entry_in  (chain[i-1]),
                .entry_out (chain[i]),
                .stat      (cell_stat[i])
            );
        end
    end

    // merge of per-cell results, at most one cell matches
    always_comb begin
        hit_mac = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_mac = hit_mac | cell_stat[i].mac;
        end
    end
    assign any_hit = |match_vec;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iptm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = iptm_pkg::ST_CMP;
                end
            end
            iptm_pkg::ST_CMP: begin
                state_next = iptm_pkg::ST_DEC;
            end
            iptm_pkg::ST_DEC: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = iptm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iptm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        cmp_en        = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            iptm_pkg::ST_IDLE: s_axis_tready = 1'b1;
            iptm_pkg::ST_CMP:  cmp_en = 1'b1;
            iptm_pkg::ST_DEC:  out_load = !m_valid_reg || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // decision
    always_comb begin
        status_next = iptm_pkg::STAT_MISS;
        mac_next    = '0;
        shift_en    = 1'b0;
        count_next  = count_reg;
        if (iptm_pkg::func_t'(func_reg) == iptm_pkg::FUNC_LEARN) begin
            if (use_fixed_reg || key_reg == '0 || any_hit) begin
                status_next = iptm_pkg::STAT_SKIPPED;
            end else if (count_reg == CNT_W'(TABLE_ENTRIES)) begin
                status_next = iptm_pkg::STAT_FULL;
            end else begin
                status_next = iptm_pkg::STAT_ADDED;
                shift_en    = out_load;
                if (out_load) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end else begin
            if (use_fixed_reg) begin
                status_next = iptm_pkg::STAT_HIT;
                mac_next    = fixed_mac_reg;
            end else if (key_reg != '0 && any_hit) begin
                status_next = iptm_pkg::STAT_HIT;
                mac_next    = hit_mac;
            end
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iptm_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_next;
            m_mac_reg    <= mac_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_mac_reg;

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == iptm_pkg::ST_DEC |-> $onehot0(match_vec))
        else $error("more than one slot matched");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count out of range");

    a_add_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_next == iptm_pkg::STAT_ADDED)
        |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("added entry without count step");

    a_accept_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == iptm_pkg::ST_CMP)
        else $error("accepted word not compared");

endmodule

/* rtl/iptm_cell.sv */
// ----------------------------------------------------------------------------
// iptm_cell
// One table slot: holds an ip/mac pair, shifts it to the next slot on insert
// and registers its own compare result against the broadcast key.
// ----------------------------------------------------------------------------
module iptm_cell (
    input  logic                aclk,
    input  iptm_pkg::cell_ctrl_t ctrl,
    input  iptm_pkg::entry_t    entry_in,
    output iptm_pkg::entry_t    entry_out,
    output iptm_pkg::cell_stat_t stat
);

    iptm_pkg::entry_t     entry_reg;
    iptm_pkg::cell_stat_t stat_reg;
    iptm_pkg::cell_stat_t stat_next;

    always_comb begin
        stat_next.match = ctrl.active && (entry_reg.ip == ctrl.key);
        stat_next.mac   = stat_next.match ? entry_reg.mac : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            entry_reg <= entry_in;
        end
        if (ctrl.cmp) begin
            stat_reg <= stat_next;
        end
    end

    assign entry_out = entry_reg;
    assign stat      = stat_reg;

endmodule

/* sim/ip_to_mac_learning_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// ip_to_mac_learning_table_unit_tb
// Self-checking bench for the ip to mac learning table. Requests go in on
// s_axis from a queue, a local table model predicts the status and mac of each
// response, and every m_axis word is compared in order. Both sides idle at
// random, and the run steps through learn and fixed-mac settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ip_to_mac_learning_table_unit_tb;

    localparam int N_SLOTS  = iptm_pkg::TABLE_ENTRIES_DEF;
    localparam int POOL_SZ  = 48;
    localparam int PHASE_SZ = 266;

    typedef struct {
        iptm_pkg::func_t            func;
        logic [iptm_pkg::IP_W-1:0]  ip;
        logic [iptm_pkg::MAC_W-1:0] mac;
    } req_t;

    typedef struct {
        iptm_pkg::status_t          status;
        logic [iptm_pkg::MAC_W-1:0] mac;
    } resp_t;

    logic                               aclk          = 1'b0;
    logic                               aresetn       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [iptm_pkg::S_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                               s_axis_tuser  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [iptm_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic [iptm_pkg::STATUS_W-1:0]      m_axis_tuser;
    logic                               cfg_valid     = 1'b0;
    logic                               cfg_ready;
    logic [iptm_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [iptm_pkg::MAC_W-1:0]         cfg_data      = '0;

    // model of the table and its configuration
    logic [iptm_pkg::IP_W-1:0]  ip_slots  [N_SLOTS];
    logic [iptm_pkg::MAC_W-1:0] mac_slots [N_SLOTS];
    int                         n_filled  = 0;
    logic                       fixed_on  = 1'b0;
    logic [iptm_pkg::MAC_W-1:0] fixed_val = '0;

    req_t        req_q[$];
    resp_t       expected_resp[$];
    req_t        cur_req;
    logic [31:0] ip_pool [POOL_SZ];

    int   errors    = 0;
    int   n_checked = 0;
    int   n_phases  = 0;
    int   stat_cnt [5];
    bit   s_taken   = 0;
    bit   m_taken   = 0;
    bit   s_quiet   = 0;
    bit   m_quiet   = 0;
    int   s_gap     = 0;
    int   m_stall   = 0;

    ip_to_mac_learning_table_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic resp_t resolve_request(input req_t r);
        resp_t res;
        int    hit;
        hit = -1;
        res.status = iptm_pkg::STAT_MISS;
        res.mac    = '0;
        for (int i = 0; i < n_filled; i++) begin
            if (hit < 0 && ip_slots[i] == r.ip) hit = i;
        end
        if (r.func == iptm_pkg::FUNC_LEARN) begin
            if (fixed_on || r.ip == '0 || hit >= 0) begin
                res.status = iptm_pkg::STAT_SKIPPED;
            end else if (n_filled >= N_SLOTS) begin
                res.status = iptm_pkg::STAT_FULL;
            end else begin
                ip_slots[n_filled]  = r.ip;
                mac_slots[n_filled] = r.mac;
                n_filled++;
                res.status = iptm_pkg::STAT_ADDED;
            end
        end else if (fixed_on) begin
            res.status = iptm_pkg::STAT_HIT;
            res.mac    = fixed_val;
        end else if (r.ip != '0 && hit >= 0) begin
            res.status = iptm_pkg::STAT_HIT;
            res.mac    = mac_slots[hit];
        end
        return res;
    endfunction

    function automatic int draw_wait(input bit quiet);
        if (quiet) return 0;
        return $urandom_range(0, 18);
    endfunction

    // accepted words: predict on input, check on output
    always @(posedge aclk) begin
        resp_t e;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            e = resolve_request(cur_req);
            expected_resp.push_back(e);
            stat_cnt[int'(e.status)]++;
            s_taken = 1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            m_taken = 1;
            n_checked++;
            if (expected_resp.size() == 0) begin
                errors++;
                $display("%0t: unexpected word status %0d mac %h", $time,
                         m_axis_tuser, m_axis_tdata);
            end else begin
                e = expected_resp.pop_front();
                if (m_axis_tuser != e.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, m_axis_tuser);
                end
                if (m_axis_tdata != e.mac) begin
                    errors++;
                    $display("%0t: mac expected %h actual %h", $time,
                             e.mac, m_axis_tdata);
                end
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        logic v;
        v = s_axis_tvalid;
        if (s_taken) begin
            s_taken = 0;
            v = 1'b0;
            if ($urandom_range(0, 39) == 0) s_quiet = ~s_quiet;
            s_gap = draw_wait(s_quiet);
        end
        if (!v && aresetn) begin
            if (s_gap > 0) begin
                s_gap--;
            end else if (req_q.size() > 0) begin
                cur_req = req_q.pop_front();
                v = 1'b1;
                s_axis_tdata <= {cur_req.mac, cur_req.ip};
                s_axis_tuser <= cur_req.func;
            end
        end
        s_axis_tvalid <= v;
    end

    // response ready
    always @(negedge aclk) begin
        if (m_taken) begin
            m_taken = 0;
            if ($urandom_range(0, 39) == 0) m_quiet = ~m_quiet;
            m_stall = draw_wait(m_quiet);
        end
        if (m_stall > 0) begin
            m_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn;
        end
    end

    task automatic write_reg(input iptm_pkg::cfg_idx_t idx,
                             input logic [iptm_pkg::MAC_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == iptm_pkg::CFG_USE_FIXED) fixed_on = val[0];
        else fixed_val = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input iptm_pkg::func_t f,
                            input logic [iptm_pkg::IP_W-1:0] ip,
                            input logic [iptm_pkg::MAC_W-1:0] mac);
        req_t r;
        r.func = f;
        r.ip   = ip;
        r.mac  = mac;
        req_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || s_axis_tvalid || expected_resp.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        n_phases++;
    endtask

    task automatic random_phase(input int count);
        logic [iptm_pkg::IP_W-1:0] ip;
        int                        pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) ip = ip_pool[$urandom_range(0, POOL_SZ - 1)];
            else if (pick < 82) ip = '0;
            else if (pick < 85) ip = '1;
            else ip = $urandom;
            push_req(iptm_pkg::func_t'($urandom_range(0, 1)), ip,
                     48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SZ; i++) ip_pool[i] = ($urandom & 32'hFFFF_FF00) | (i + 1);
        foreach (stat_cnt[i]) stat_cnt[i] = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // learn mode corner cases
        push_req(iptm_pkg::FUNC_LOOKUP, '0, '0);
        push_req(iptm_pkg::FUNC_LEARN,  '0, 48'h0123_4567_89AB);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h0A00_0001, '1);
        push_req(iptm_pkg::FUNC_LEARN,  '1, '1);
        push_req(iptm_pkg::FUNC_LOOKUP, '1, '0);
        push_req(iptm_pkg::FUNC_LEARN,  '1, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, '1, 48'h5555_5555_5555);
        push_req(iptm_pkg::FUNC_LEARN,  32'h0000_0001, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h0000_0001, '1);
        push_req(iptm_pkg::FUNC_LEARN,  32'h8000_0000, 48'h8000_0000_0000);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h8000_0000, 48'hAAAA_AAAA_AAAA);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h8000_0001, '0);
        wait_idle();

        // fixed destination mode
        write_reg(iptm_pkg::CFG_FIXED_MAC, '1);
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd1);
        push_req(iptm_pkg::FUNC_LEARN,  32'h0C0A_0B0D, 48'h0000_1111_2222);
        push_req(iptm_pkg::FUNC_LOOKUP, '0, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h0C0A_0B0D, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, '1, '0);
        push_req(iptm_pkg::FUNC_LEARN,  '0, '1);
        wait_idle();
        write_reg(iptm_pkg::CFG_FIXED_MAC, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h1234_5678, '1);
        wait_idle();
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd0);
        push_req(iptm_pkg::FUNC_LOOKUP, 32'h0C0A_0B0D, '0);
        push_req(iptm_pkg::FUNC_LOOKUP, '1, '0);
        wait_idle();

        write_reg(iptm_pkg::CFG_FIXED_MAC, 48'({$urandom, $urandom}));
        random_phase(PHASE_SZ);
        wait_idle();
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd1);
        random_phase(PHASE_SZ);
        wait_idle();
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd0);
        write_reg(iptm_pkg::CFG_FIXED_MAC, '0);
        random_phase(PHASE_SZ);
        wait_idle();
        write_reg(iptm_pkg::CFG_FIXED_MAC, '1);
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd1);
        random_phase(PHASE_SZ);
        wait_idle();
        write_reg(iptm_pkg::CFG_USE_FIXED, 48'd0);
        random_phase(PHASE_SZ);
        wait_idle();
        repeat (10) @(posedge aclk);

        $display("%0d responses over %0d phases, %0d of %0d slots filled",
                 n_checked, n_phases, n_filled, N_SLOTS);
        $display("added %0d, present/skipped %0d, full %0d, hit %0d, miss %0d",
                 stat_cnt[0], stat_cnt[1], stat_cnt[2], stat_cnt[3], stat_cnt[4]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", expected_resp.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/iptm_pkg.sv
rtl/iptm_cell.sv
rtl/ip_to_mac_learning_table_unit.sv
sim/ip_to_mac_learning_table_unit_tb.sv
